>>> hw/rtl/lfp_pkg.sv
// Package for the lidar frame parser: frame constants, parse phase codes
// and the result record shared by the parser, output register and top level.
// No dependencies.
package lfp_pkg;

	// Frame framing constants.
	localparam logic [7:0] SyncByte     = 8'hFA;
	localparam logic [7:0] IndexLow     = 8'hA0;
	localparam logic [7:0] IndexHigh    = 8'hF9;
	localparam int         FoldShift    = 15;
	localparam int         InvalidBit   = 7;
	localparam int         DistHighBits = 6;

	// Frame positions (byte offsets within the 22-byte frame).
	localparam logic [4:0] FirstDataPos = 5'd2;
	localparam logic [4:0] SpeedPos     = 5'd3;
	localparam logic [4:0] FirstDistPos = 5'd5;
	localparam logic [4:0] LastDistPos  = 5'd17;
	localparam logic [4:0] LastPos      = 5'd21;

	// Parse phase codes.
	localparam logic [1:0] PhHunt    = 2'd0;
	localparam logic [1:0] PhIndex   = 2'd1;
	localparam logic [1:0] PhCollect = 2'd2;

	localparam int NumDist  = 4;
	localparam int DistW    = 14;
	localparam int SumW     = 26;

	// One completed frame as delivered on the result channel.
	typedef struct packed {
		logic [7:0]                        frame_index;
		logic [15:0]                       motor_speed;
		logic                              checksum_ok;
		logic [NumDist-1:0][DistW-1:0]     distance;
		logic [NumDist-1:0]                dist_valid;
	} frame_res_t;

	// Parser status seen by the top level.
	typedef struct packed {
		logic [1:0] phase;
		logic [4:0] position;
	} parse_stat_t;

endpackage

>>> hw/rtl/lfp_parser.sv
// Byte-level frame parser: sync hunt, index check, word assembly, running
// checksum and field capture. Flags the frame-ending byte combinationally.
// Depends on lfp_pkg.
module lfp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  logic                step,
	output logic                frame_done,
	output lfp_pkg::frame_res_t result,
	output lfp_pkg::parse_stat_t stat
);

	logic [1:0]  phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic [lfp_pkg::SumW-1:0] sum_q, sum_d;
	logic        sum_we;
	logic [7:0]  pend_q;
	logic        pend_we;
	logic [7:0]  index_q;
	logic        index_we;
	logic [15:0] speed_q;
	logic        speed_we;
	logic [lfp_pkg::NumDist-1:0][lfp_pkg::DistW-1:0] dist_q;
	logic [lfp_pkg::NumDist-1:0] vld_q;
	logic        dist_we;
	logic [4:0]  dist_off;
	logic [1:0]  dist_sel;
	logic [15:0] word;
	logic [15:0] fold_sum;
	logic        index_in_range;
	logic        cks_ok;

	// Word assembled from the pending low byte and the current high byte.
	assign word           = {rx_byte, pend_q};
	assign index_in_range = (rx_byte >= lfp_pkg::IndexLow) && (rx_byte <= lfp_pkg::IndexHigh);
	assign dist_off       = pos_q - lfp_pkg::FirstDistPos;
	assign dist_sel       = dist_off[3:2];

	// Next-state logic for phase, position and the capture enables.
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		sum_d      = sum_q;
		sum_we     = 1'b0;
		pend_we    = 1'b0;
		index_we   = 1'b0;
		speed_we   = 1'b0;
		dist_we    = 1'b0;
		frame_done = 1'b0;
		unique case (phase_q)
			lfp_pkg::PhIndex: begin
				if (index_in_range) begin
					index_we = 1'b1;
					sum_we   = 1'b1;
					sum_d    = {10'd0, rx_byte, lfp_pkg::SyncByte};
					pos_d    = lfp_pkg::FirstDataPos;
					phase_d  = lfp_pkg::PhCollect;
				end else begin
					phase_d = lfp_pkg::PhHunt;
				end
			end
			lfp_pkg::PhCollect: begin
				if (!pos_q[0]) begin
					pend_we = 1'b1;
					pos_d   = pos_q + 5'd1;
				end else if (pos_q < lfp_pkg::LastPos) begin
					sum_we   = 1'b1;
					sum_d    = {sum_q[lfp_pkg::SumW-2:0], 1'b0} + {10'd0, word};
					speed_we = (pos_q == lfp_pkg::SpeedPos);
					dist_we  = (pos_q >= lfp_pkg::FirstDistPos) &&
						(pos_q <= lfp_pkg::LastDistPos) && (dist_off[1:0] == 2'b00);
					pos_d    = pos_q + 5'd1;
				end else begin
					frame_done = 1'b1;
					phase_d    = lfp_pkg::PhHunt;
					pos_d      = 5'd0;
				end
			end
			default: begin
				// Hunting, and the unused phase code behaves the same.
				phase_d = (rx_byte == lfp_pkg::SyncByte) ? lfp_pkg::PhIndex : lfp_pkg::PhHunt;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfp_pkg::PhHunt;
			pos_q   <= 5'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	// Frame field holding registers.
	always_ff @(posedge clk) begin
		if (step) begin
			if (sum_we)   sum_q   <= sum_d;
			if (pend_we)  pend_q  <= rx_byte;
			if (index_we) index_q <= rx_byte;
			if (speed_we) speed_q <= word;
			if (dist_we) begin
				vld_q[dist_sel]  <= ~rx_byte[lfp_pkg::InvalidBit];
				dist_q[dist_sel] <= {rx_byte[lfp_pkg::DistHighBits-1:0], pend_q};
			end
		end
	end

	// Fold the running sum to 15 bits and compare with the received word.
	assign fold_sum = {1'b0, sum_q[lfp_pkg::FoldShift-1:0]} +
		{5'd0, sum_q[lfp_pkg::SumW-1:lfp_pkg::FoldShift]};
	assign cks_ok   = ({1'b0, fold_sum[lfp_pkg::FoldShift-1:0]} == word);

	// Result record; distances are zeroed when invalid or on checksum failure.
	always_comb begin
		result.frame_index = index_q;
		result.motor_speed = speed_q;
		result.checksum_ok = cks_ok;
		for (int k = 0; k < lfp_pkg::NumDist; k++) begin
			result.dist_valid[k] = cks_ok & vld_q[k];
			result.distance[k]   = (cks_ok & vld_q[k]) ? dist_q[k] : '0;
		end
	end

	assign stat.phase    = phase_q;
	assign stat.position = pos_q;

endmodule

>>> hw/rtl/lfp_out_reg.sv
// Result register for the frame parser output channel: holds one result
// beat until the consumer takes it. Depends on lfp_pkg.
module lfp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lfp_pkg::frame_res_t load_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                can_load,
	output lfp_pkg::frame_res_t data
);

	logic               valid_q;
	lfp_pkg::frame_res_t data_q;

	// The slot is free when empty or when its beat leaves this cycle.
	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign data      = data_q;

endmodule

>>> hw/rtl/lidar_frame_parser_core.sv
// Top level of the lidar frame parser: input register, parser and result
// register. Depends on lfp_pkg, lfp_parser and lfp_out_reg.
//
//   channel | signals                          | beat
//   input   | in_valid, in_ready, rx_byte      | one received byte
//   result  | out_valid, out_ready, fields     | one parsed frame
//
// One byte is taken per cycle while the input is not stalled. A byte is captured
// in the input register and parsed from there, and a frame result is loaded into
// the result register when the final byte is parsed. The input stalls only when a
// frame's final byte sits in the input register while the result register still
// holds an untaken frame. Reset returns the parser to sync hunting and empties
// both registers.
module lidar_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_index,
	output logic [15:0] motor_speed,
	output logic        checksum_ok,
	output logic [13:0] dist_a,
	output logic [13:0] dist_b,
	output logic [13:0] dist_c,
	output logic [13:0] dist_d,
	output logic        valid_a,
	output logic        valid_b,
	output logic        valid_c,
	output logic        valid_d
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 frame_done;
	logic                 can_load;
	lfp_pkg::frame_res_t  result;
	lfp_pkg::frame_res_t  res_out;
	lfp_pkg::parse_stat_t stat;

	// The held byte advances unless it ends a frame and the result slot is full.
	assign advance  = valid_s1 && (!frame_done || can_load);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	lfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (byte_s1),
		.step       (advance),
		.frame_done (frame_done),
		.result     (result),
		.stat       (stat)
	);

	lfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && frame_done),
		.load_data (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (can_load),
		.data      (res_out)
	);

	// Result fields.
	assign frame_index = res_out.frame_index;
	assign motor_speed = res_out.motor_speed;
	assign checksum_ok = res_out.checksum_ok;
	assign dist_a      = res_out.distance[0];
	assign dist_b      = res_out.distance[1];
	assign dist_c      = res_out.distance[2];
	assign dist_d      = res_out.distance[3];
	assign valid_a     = res_out.dist_valid[0];
	assign valid_b     = res_out.dist_valid[1];
	assign valid_c     = res_out.dist_valid[2];
	assign valid_d     = res_out.dist_valid[3];

	// A frame-ending byte must wait while an untaken result is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && frame_done && out_valid && !out_ready) |-> !in_ready)
		else $error("frame end advanced over a held result");

	// While collecting, the position stays inside the data part of the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat.phase == lfp_pkg::PhCollect) |->
		(stat.position >= lfp_pkg::FirstDataPos && stat.position <= lfp_pkg::LastPos))
		else $error("byte position out of frame range");

	// A failed checksum delivers no distances and no valid flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !checksum_ok) |->
		(!valid_a && !valid_b && !valid_c && !valid_d &&
		dist_a == 14'd0 && dist_b == 14'd0 && dist_c == 14'd0 && dist_d == 14'd0))
		else $error("distances given on checksum failure");

	// An empty input register always accepts.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

>>> tb/lfp_frame_check.sv
`timescale 1ns / 1ps
// Checker for the lidar frame parser: follows the byte beats into the block,
// predicts each parsed frame and compares it with the result beats.
// Depends on lfp_pkg for the frame constants, phase codes and result record.
module lfp_frame_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  frame_index,
	input  logic [15:0] motor_speed,
	input  logic        checksum_ok,
	input  logic [13:0] dist_a,
	input  logic [13:0] dist_b,
	input  logic [13:0] dist_c,
	input  logic [13:0] dist_d,
	input  logic        valid_a,
	input  logic        valid_b,
	input  logic        valid_c,
	input  logic        valid_d,
	output int          mismatches,
	output int          frames_pending,
	output int          frames_done
);

	// Shadow copy of the parser state.
	logic [1:0]               phase;
	logic [4:0]               position;
	logic [lfp_pkg::SumW-1:0] run_sum;
	logic [7:0]               low_byte;
	logic [7:0]               index_q;
	logic [15:0]              speed_q;
	logic [13:0]              dist_q [lfp_pkg::NumDist];
	logic                     vld_q [lfp_pkg::NumDist];

	// Parsed frames that are still due on the result channel, oldest first.
	lfp_pkg::frame_res_t      frames_due [$];

	// One step of the running checksum: shift left by one and add the word.
	function automatic logic [lfp_pkg::SumW-1:0] sum_step(
			input logic [lfp_pkg::SumW-1:0] acc, input logic [15:0] word);
		return {acc[lfp_pkg::SumW-2:0], 1'b0} + {{(lfp_pkg::SumW-16){1'b0}}, word};
	endfunction

	// Advance the shadow parser by one byte and queue a frame when it completes.
	function automatic void parse_byte(input logic [7:0] b);
		logic [15:0]         word;
		logic [15:0]         folded;
		logic [4:0]          rel;
		logic                ok;
		lfp_pkg::frame_res_t res;
		int                  k;
		word = {b, low_byte};
		rel  = position - lfp_pkg::FirstDistPos;
		case (phase)
			lfp_pkg::PhIndex: begin
				if (b >= lfp_pkg::IndexLow && b <= lfp_pkg::IndexHigh) begin
					index_q  = b;
					run_sum  = sum_step('0, {b, lfp_pkg::SyncByte});
					position = lfp_pkg::FirstDataPos;
					phase    = lfp_pkg::PhCollect;
				end else begin
					phase = lfp_pkg::PhHunt;
				end
			end
			lfp_pkg::PhCollect: begin
				if (!position[0]) begin
					low_byte = b;
					position = position + 5'd1;
				end else if (position < lfp_pkg::LastPos) begin
					run_sum = sum_step(run_sum, word);
					if (position == lfp_pkg::SpeedPos) begin
						speed_q = word;
					end else if (position >= lfp_pkg::FirstDistPos &&
							position <= lfp_pkg::LastDistPos && rel[1:0] == 2'd0) begin
						vld_q[rel[3:2]]  = !b[lfp_pkg::InvalidBit];
						dist_q[rel[3:2]] = {b[lfp_pkg::DistHighBits-1:0], low_byte};
					end
					position = position + 5'd1;
				end else begin
					// Fold the sum to 15 bits and compare with the received word.
					folded = {1'b0, run_sum[lfp_pkg::FoldShift-1:0]} +
						{{(16-(lfp_pkg::SumW-lfp_pkg::FoldShift)){1'b0}},
						run_sum[lfp_pkg::SumW-1:lfp_pkg::FoldShift]};
					ok = (word == {1'b0, folded[14:0]});
					res.frame_index = index_q;
					res.motor_speed = speed_q;
					res.checksum_ok = ok;
					for (k = 0; k < lfp_pkg::NumDist; k++) begin
						res.dist_valid[k] = ok && vld_q[k];
						res.distance[k]   = (ok && vld_q[k]) ? dist_q[k] : '0;
					end
					frames_due.push_back(res);
					phase    = lfp_pkg::PhHunt;
					position = '0;
				end
			end
			default: begin
				phase = (b == lfp_pkg::SyncByte) ? lfp_pkg::PhIndex : lfp_pkg::PhHunt;
			end
		endcase
	endfunction

	// Print one line for a wrong field and count it.
	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Compare one result beat with the oldest frame due.
	task automatic check_result();
		lfp_pkg::frame_res_t want;
		logic [13:0]         got_dist [lfp_pkg::NumDist];
		logic                got_vld [lfp_pkg::NumDist];
		int                  k;
		got_dist = '{dist_a, dist_b, dist_c, dist_d};
		got_vld  = '{valid_a, valid_b, valid_c, valid_d};
		if (frames_due.size() == 0) begin
			report("result beat with no frame due, out_valid", 16'd1, 16'd0);
		end else begin
			want = frames_due.pop_front();
			frames_done++;
			if (frame_index !== want.frame_index) begin
				report("frame_index", {8'd0, frame_index}, {8'd0, want.frame_index});
			end
			if (motor_speed !== want.motor_speed) begin
				report("motor_speed", motor_speed, want.motor_speed);
			end
			if (checksum_ok !== want.checksum_ok) begin
				report("checksum_ok", {15'd0, checksum_ok}, {15'd0, want.checksum_ok});
			end
			for (k = 0; k < lfp_pkg::NumDist; k++) begin
				if (got_dist[k] !== want.distance[k]) begin
					report($sformatf("distance %0d", k), {2'd0, got_dist[k]},
						{2'd0, want.distance[k]});
				end
				if (got_vld[k] !== want.dist_valid[k]) begin
					report($sformatf("valid flag %0d", k), {15'd0, got_vld[k]},
						{15'd0, want.dist_valid[k]});
				end
			end
		end
	endtask

	// Watch both channels; a result beat is checked before a byte beat is parsed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase          = lfp_pkg::PhHunt;
			position       = '0;
			run_sum        = '0;
			low_byte       = '0;
			index_q        = '0;
			speed_q        = '0;
			dist_q         = '{default: '0};
			vld_q          = '{default: 1'b0};
			frames_due.delete();
			mismatches     = 0;
			frames_pending = 0;
			frames_done    = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
			end
			if (in_valid && in_ready) begin
				parse_byte(rx_byte);
			end
			frames_pending = frames_due.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the lidar frame parser testbench: clock, reset, byte stimulus and
// result-side stalls, with the verdict. Depends on lfp_pkg,
// lidar_frame_parser_core and lfp_frame_check.
module tb;

	localparam int ByteTarget = 1650;
	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 500;
	localparam int MaxGap     = 17;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_index;
	logic [15:0] motor_speed;
	logic        checksum_ok;
	logic [13:0] dist_a;
	logic [13:0] dist_b;
	logic [13:0] dist_c;
	logic [13:0] dist_d;
	logic        valid_a;
	logic        valid_b;
	logic        valid_c;
	logic        valid_d;
	int          mismatches;
	int          frames_pending;
	int          frames_done;

	int          bytes_sent;
	int          cycles;
	int          send_run;
	bit          send_gaps;
	int          recv_run;
	bit          recv_gaps;
	logic [7:0]  frame_buf [0:21];

	lidar_frame_parser_core i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
		.frame_index, .motor_speed, .checksum_ok, .dist_a, .dist_b, .dist_c, .dist_d,
		.valid_a, .valid_b, .valid_c, .valid_d
	);

	lfp_frame_check i_check (
		.clk, .arst_n, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
		.frame_index, .motor_speed, .checksum_ok, .dist_a, .dist_b, .dist_c, .dist_d,
		.valid_a, .valid_b, .valid_c, .valid_d, .mismatches, .frames_pending, .frames_done
	);

	// Clock with a 20 ns period.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Run limit counted in clock cycles.
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("status: fail");
		$finish;
	end

	// Offer one byte beat after a random gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (send_run == 0) begin
			send_gaps = ($urandom_range(0, 2) != 0);
			send_run  = $urandom_range(20, 60);
		end
		send_run--;
		gap = send_gaps ? $urandom_range(0, MaxGap) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
		bytes_sent++;
	endtask

	// Pick an index byte, with the range ends drawn often.
	function automatic logic [7:0] pick_index();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return lfp_pkg::IndexLow;
		end else if (r == 1) begin
			return lfp_pkg::IndexHigh;
		end
		return 8'($urandom_range(lfp_pkg::IndexLow, lfp_pkg::IndexHigh));
	endfunction

	// Sync, index and random body bytes.
	function automatic void fill_frame(input logic [7:0] idx);
		int i;
		frame_buf[0] = lfp_pkg::SyncByte;
		frame_buf[1] = idx;
		for (i = 2; i < 22; i++) begin
			frame_buf[i] = 8'($urandom_range(0, 255));
		end
	endfunction

	// Write the checksum word; mode 1 then flips one bit of the body or the
	// checksum, mode 2 sets bit 15 of the checksum word.
	function automatic void seal_frame(input int mode);
		logic [25:0] acc;
		logic [15:0] folded;
		int          w;
		int          spot;
		acc = '0;
		for (w = 0; w < 10; w++) begin
			acc = {acc[24:0], 1'b0} + {10'd0, frame_buf[2*w+1], frame_buf[2*w]};
		end
		folded = {1'b0, acc[14:0]} + {5'd0, acc[25:15]};
		frame_buf[20] = folded[7:0];
		frame_buf[21] = {1'b0, folded[14:8]};
		if (mode == 1) begin
			spot = $urandom_range(16, 175);
			frame_buf[spot/8] = frame_buf[spot/8] ^ (8'd1 << (spot % 8));
		end else if (mode == 2) begin
			frame_buf[21][7] = 1'b1;
		end
	endfunction

	// Send the first count bytes of the frame buffer.
	task automatic send_frame(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_byte(frame_buf[i]);
		end
	endtask

	// Result side: random stalls per beat, calm stretches, and two long hold-offs
	// that let the block fill up and stall its input.
	initial begin
		int wait_len;
		int taken;
		taken    = 0;
		recv_run = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (recv_run == 0) begin
				recv_gaps = ($urandom_range(0, 2) != 0);
				recv_run  = $urandom_range(5, 20);
			end
			recv_run--;
			if (taken == 3 || taken == 30) begin
				wait_len = HoldCycles;
			end else begin
				wait_len = recv_gaps ? $urandom_range(0, MaxGap) : 0;
			end
			if (wait_len > 0) begin
				out_ready <= 1'b0;
				repeat (wait_len) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
			taken++;
		end
	end

	// Reset, directed bytes, random frame traffic, drain and verdict.
	initial begin
		int pick;
		int r;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		out_ready  = 1'b0;
		bytes_sent = 0;
		send_run   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sync followed by index bytes just outside the range on each side.
		send_byte(lfp_pkg::SyncByte);
		send_byte(lfp_pkg::IndexLow - 8'd1);
		send_byte(lfp_pkg::SyncByte);
		send_byte(lfp_pkg::IndexHigh + 8'd1);
		// A sync byte in the index slot is dropped, so the next index is ignored.
		send_byte(lfp_pkg::SyncByte);
		send_byte(lfp_pkg::SyncByte);
		send_byte(lfp_pkg::IndexLow);

		// Frame at the extremes: top index, full speed, largest valid distance,
		// zero distance, and two invalid distances.
		fill_frame(lfp_pkg::IndexHigh);
		frame_buf[2]  = 8'hFF;
		frame_buf[3]  = 8'hFF;
		frame_buf[4]  = 8'hFF;
		frame_buf[5]  = 8'h3F;
		frame_buf[8]  = 8'h00;
		frame_buf[9]  = 8'h00;
		frame_buf[12] = 8'hFF;
		frame_buf[13] = 8'hFF;
		frame_buf[16] = 8'h00;
		frame_buf[17] = 8'hC0;
		seal_frame(0);
		send_frame(22);

		// Mostly whole frames with random content; the rest is noise, bad
		// indexes, truncated frames and corrupted checksums.
		while (bytes_sent < ByteTarget) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 25) begin
				send_byte(lfp_pkg::SyncByte);
				if ($urandom_range(0, 1) != 0) begin
					send_byte(8'($urandom_range(0, lfp_pkg::IndexLow - 1)));
				end else begin
					send_byte(8'($urandom_range(lfp_pkg::IndexHigh + 1, 255)));
				end
			end else if (pick < 32) begin
				fill_frame(pick_index());
				seal_frame(0);
				send_frame($urandom_range(2, 21));
			end else begin
				fill_frame(pick_index());
				r = $urandom_range(0, 9);
				seal_frame((r < 7) ? 0 : ((r < 9) ? 1 : 2));
				send_frame(22);
			end
		end
		in_valid <= 1'b0;

		// Drain the frames still due, then allow for the pipeline latency.
		while (frames_pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("sent %0d bytes and checked %0d frames: good, corrupted, truncated,",
			bytes_sent, frames_done);
		$display("bad-index and noise traffic under random stalls and long output hold-offs");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/lfp_pkg.sv
hw/rtl/lfp_parser.sv
hw/rtl/lfp_out_reg.sv
hw/rtl/lidar_frame_parser_core.sv
tb/lfp_frame_check.sv
tb/tb.sv
